// ===== src/tsa_pkg.sv =====
`default_nettype none
package tsa_pkg;

	localparam int SLOT_W      = 12;
	localparam int HOST_W      = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [SLOT_W-1:0] FRAME_SLOTS_RST   = 12'd64;
	localparam logic [SLOT_W-1:0] REQUEST_SLOTS_RST = 12'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SLOTS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_SLOTS = 1'd1;

	localparam logic FUNC_REQUEST = 1'b0;
	localparam logic FUNC_TICK    = 1'b1;

	typedef struct packed {
		logic              tick;
		logic [HOST_W-1:0] host;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_count;
		logic [SLOT_W-1:0] slot_start;
		logic [HOST_W-1:0] grant_host;
	} grant_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_EMIT
	} back_state_t;

endpackage
`default_nettype wire

// ===== src/tsa_ram.sv =====
`default_nettype none
module tsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/tsa_front.sv =====
`default_nettype none
module tsa_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      in_func,
	input  wire logic [tsa_pkg::HOST_W-1:0] in_host,
	output logic                           cmd_valid,
	output tsa_pkg::cmd_t                  cmd,
	input  wire logic                      cmd_pop
);

	tsa_pkg::cmd_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].tick <= (in_func == tsa_pkg::FUNC_TICK);
			fifo_q[wr_ptr_q].host <= in_host;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/tsa_divider.sv =====
`default_nettype none
module tsa_divider #(
	parameter int DIV_W = 5
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [tsa_pkg::SLOT_W-1:0] dividend,
	input  wire logic [DIV_W-1:0]           divisor,
	output logic                            done,
	output logic      [tsa_pkg::SLOT_W-1:0] quotient,
	output logic      [DIV_W-1:0]           remainder
);

	localparam int STEP_W = $clog2(tsa_pkg::SLOT_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(tsa_pkg::SLOT_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [tsa_pkg::SLOT_W-1:0] quo_q;
	logic [DIV_W-1:0]           rem_q;
	logic [DIV_W-1:0]           dsr_q;
	logic [DIV_W:0]             trial;
	logic                       fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[tsa_pkg::SLOT_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
			quo_q <= {quo_q[tsa_pkg::SLOT_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/tsa_back.sv =====
`default_nettype none
module tsa_back #(
	parameter int QUEUE_DEPTH = tsa_pkg::QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [tsa_pkg::SLOT_W-1:0] frame_slots,
	input  wire logic [tsa_pkg::SLOT_W-1:0] request_slots,
	input  wire logic                       cmd_valid,
	input  wire tsa_pkg::cmd_t              cmd,
	output logic                            cmd_pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output tsa_pkg::grant_t                 out_grant,
	output logic                            out_last
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	tsa_pkg::back_state_t state_q, state_d;

	logic [CNT_W-1:0]           cnt_q;
	logic [IDX_W-1:0]           idx_q;
	logic [tsa_pkg::SLOT_W-1:0] pos_q;
	logic                       out_valid_q;
	tsa_pkg::grant_t            grant_q;
	logic                       last_q;

	logic                       ram_we;
	logic [tsa_pkg::HOST_W-1:0] ram_rdata;
	logic                       div_start;
	logic                       div_done;
	logic [tsa_pkg::SLOT_W-1:0] share;
	logic [CNT_W-1:0]           extra;
	logic [tsa_pkg::SLOT_W-1:0] data_slots;
	logic                       out_free;
	logic                       emit;
	logic                       is_last;
	logic [tsa_pkg::SLOT_W-1:0] grant_cnt;

	assign data_slots = (frame_slots > request_slots) ? (frame_slots - request_slots) : '0;
	assign out_free   = !out_valid_q || out_ready;
	assign is_last    = (CNT_W'(idx_q) + 1'b1 == cnt_q);
	assign grant_cnt  = share + {{(tsa_pkg::SLOT_W-1){1'b0}}, (CNT_W'(idx_q) < extra)};

	assign out_valid = out_valid_q;
	assign out_grant = grant_q;
	assign out_last  = last_q;

	tsa_ram #(
		.WIDTH (tsa_pkg::HOST_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (cmd.host),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	tsa_divider #(
		.DIV_W (CNT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (data_slots),
		.divisor   (cnt_q),
		.done      (div_done),
		.quotient  (share),
		.remainder (extra)
	);

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		case (state_q)
			tsa_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (!cmd.tick) begin
						ram_we = (cnt_q < DEPTH_C);
					end else if (cnt_q != '0) begin
						div_start = 1'b1;
						state_d   = tsa_pkg::ST_DIV;
					end
				end
			end
			tsa_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = tsa_pkg::ST_READ;
				end
			end
			tsa_pkg::ST_READ: begin
				state_d = tsa_pkg::ST_EMIT;
			end
			tsa_pkg::ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = is_last ? tsa_pkg::ST_IDLE : tsa_pkg::ST_READ;
				end
			end
			default: begin
				state_d = tsa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			pos_q <= request_slots;
		end else if (emit) begin
			pos_q <= pos_q + grant_cnt;
		end
		if (emit) begin
			grant_q.grant_host <= ram_rdata;
			grant_q.slot_start <= pos_q;
			grant_q.slot_count <= grant_cnt;
			last_q             <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsa_pkg::ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (emit && is_last) begin
				cnt_q <= '0;
			end
			if (div_start || (emit && is_last)) begin
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/tdma_slot_allocator.sv =====
// TDMA slot allocator.
// Input stream: s_tuser = 0 queues the host in s_tdata, s_tuser = 1 is a frame tick.
// On a tick the data slots (frame_slots - request_slots, floored at zero) are shared
// among the queued hosts in arrival order; the first (remainder) hosts get one more.
// One grant word per host leaves on the output stream, m_tlast on the final one,
// and the queue is then emptied. A tick with an empty queue gives no words.
// Requests beyond QUEUE_DEPTH queued hosts are dropped.
// Requests: one word per cycle sustained while the back end is idle, through a two-entry command queue.
// Tick: dispatch, then the bit-serial divider (12 quotient bits, one per cycle, then
// done), then per grant a queue RAM read and an output register load.
// A stalled output holds its word; the back end waits, the command queue fills,
// and s_tready drops once it is full.
// Reset: frame_slots = 64, request_slots = 8, queue empty, output idle.
// cfg_we writes register cfg_index (0 frame_slots, 1 request_slots); the user
// must write only while idle, as the block itself does not enforce it.
`default_nettype none
module tdma_slot_allocator #(
	parameter int QUEUE_DEPTH = tsa_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsa_pkg::SLOT_W-1:0]    cfg_data,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // host_id
	input  wire logic                          s_tuser,  // func
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [31:0]                   m_tdata,  // grant_host, slot_start, slot_count
	output logic                               m_tlast
);

	logic [tsa_pkg::SLOT_W-1:0] frame_slots_q;
	logic [tsa_pkg::SLOT_W-1:0] request_slots_q;
	logic                       cmd_valid;
	tsa_pkg::cmd_t              cmd;
	logic                       cmd_pop;
	tsa_pkg::grant_t            grant;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_slots_q   <= tsa_pkg::FRAME_SLOTS_RST;
			request_slots_q <= tsa_pkg::REQUEST_SLOTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tsa_pkg::CFG_FRAME_SLOTS:   frame_slots_q   <= cfg_data;
				tsa_pkg::CFG_REQUEST_SLOTS: request_slots_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_host   (s_tdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tsa_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_slots   (frame_slots_q),
		.request_slots (request_slots_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_grant     (grant),
		.out_last      (m_tlast)
	);

	assign m_tdata = grant;

endmodule
`default_nettype wire

// ===== tb/tdma_slot_allocator_checker.sv =====
`default_nettype none
module tdma_slot_allocator_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsa_pkg::SLOT_W-1:0]    cfg_data,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [7:0]                    s_tdata,  // host_id
	input  wire logic                          s_tuser,  // func
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [31:0]                   m_tdata,  // grant_host, slot_start, slot_count
	input  wire logic                          m_tlast,
	output int                                 errors,
	output int                                 pending,
	output int                                 n_requests,
	output int                                 n_ticks,
	output int                                 n_grants,
	output int                                 n_dropped
);
	import tsa_pkg::*;

	localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef struct packed {
		logic [HOST_W-1:0] host;
		logic [SLOT_W-1:0] start;
		logic [SLOT_W-1:0] count;
		logic              last;
	} slot_grant_t;

	logic [SLOT_W-1:0] frame_slots;
	logic [SLOT_W-1:0] request_slots;
	logic [HOST_W-1:0] host_fifo [QUEUE_DEPTH];
	int unsigned       host_cnt;
	slot_grant_t       grant_q [$];

	always @(posedge clk or negedge arst_n) begin : track
		grant_t      got;
		slot_grant_t want;
		int unsigned data_slots;
		int unsigned share;
		int unsigned extra;
		int unsigned pos;
		int unsigned cnt;
		if (!arst_n) begin
			frame_slots   = FRAME_SLOTS_RST;
			request_slots = REQUEST_SLOTS_RST;
			host_cnt      = 0;
			grant_q.delete();
			errors        = 0;
			pending       = 0;
			n_requests    = 0;
			n_ticks       = 0;
			n_grants      = 0;
			n_dropped     = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FRAME_SLOTS)
					frame_slots = cfg_data;
				else if (cfg_index == CFG_REQUEST_SLOTS)
					request_slots = cfg_data;
			end

			if (m_tvalid && m_tready) begin
				got = m_tdata;
				n_grants++;
				if (grant_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected grant word host=%0d start=%0d count=%0d last=%0b",
							$realtime, got.grant_host, got.slot_start, got.slot_count, m_tlast);
				end else begin
					want = grant_q.pop_front();
					if (got.grant_host !== want.host || got.slot_start !== want.start ||
					    got.slot_count !== want.count || m_tlast !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("%0t: grant mismatch exp host=%0d start=%0d count=%0d last=%0b, %s",
								$realtime, want.host, want.start, want.count, want.last,
								$sformatf("got host=%0d start=%0d count=%0d last=%0b",
									got.grant_host, got.slot_start, got.slot_count, m_tlast));
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_TICK) begin
					n_ticks++;
					if (host_cnt != 0) begin
						data_slots = (frame_slots > request_slots) ?
							frame_slots - request_slots : 0;
						share = data_slots / host_cnt;
						extra = data_slots % host_cnt;
						pos   = request_slots;
						for (int i = 0; i < host_cnt; i++) begin
							cnt        = share + ((i < extra) ? 1 : 0);
							want.host  = host_fifo[i[QIDX_W-1:0]];
							want.start = pos[SLOT_W-1:0];
							want.count = cnt[SLOT_W-1:0];
							want.last  = (i + 1 == host_cnt);
							grant_q.push_back(want);
							pos += cnt;
						end
						host_cnt = 0;
					end
				end else begin
					n_requests++;
					if (host_cnt < QUEUE_DEPTH) begin
						host_fifo[host_cnt[QIDX_W-1:0]] = s_tdata;
						host_cnt++;
					end else begin
						n_dropped++;
					end
				end
			end
			pending = grant_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/tdma_slot_allocator_tb.sv =====
`default_nettype none
module tdma_slot_allocator_tb;
	import tsa_pkg::*;

	localparam int ITEMS  = 410;
	localparam int LIMIT  = 400000;
	localparam int SETTLE = 48;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SLOT_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;
	logic                 m_tlast;

	int errors;
	int pending;
	int n_requests;
	int n_ticks;
	int n_grants;
	int n_dropped;

	int n_sent      = 0;
	int tx_idle_pct = 21;
	int rx_idle_pct = 88;
	int cycles      = 0;

	logic [SLOT_W-1:0] phase_frame [6] = '{12'd4095, 12'd1, 12'd4095, 12'd1, 12'd300, 12'd64};
	logic [SLOT_W-1:0] phase_req   [6] = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd8};

	always #10 clk = ~clk;

	tdma_slot_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	tdma_slot_allocator_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.errors     (errors),
		.pending    (pending),
		.n_requests (n_requests),
		.n_ticks    (n_ticks),
		.n_grants   (n_grants),
		.n_dropped  (n_dropped)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d grants outstanding", cycles, pending);
			$display("** tdma_slot_allocator: FAILED **");
			$finish;
		end
	end

	task automatic send_word(input logic func, input logic [HOST_W-1:0] host);
		if (n_sent < ITEMS / 3) begin
			tx_idle_pct = 21;
			rx_idle_pct = 88;
		end else if (n_sent < 2 * ITEMS / 3) begin
			tx_idle_pct = 88;
			rx_idle_pct = 21;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= host;
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	task automatic send_frame(input int n_req);
		for (int i = 0; i < n_req; i++)
			send_word(FUNC_REQUEST, HOST_W'($urandom_range(255)));
		send_word(FUNC_TICK, HOST_W'($urandom_range(255)));
	endtask

	// wait for every grant, then let the command queue empty
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [SLOT_W-1:0] frame, input logic [SLOT_W-1:0] req);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FRAME_SLOTS;
		cfg_data  <= frame;
		@(posedge clk);
		cfg_index <= CFG_REQUEST_SLOTS;
		cfg_data  <= req;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int r;
		int n_req;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_FRAME_SLOTS;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = FUNC_REQUEST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty tick, single host, then an overfilled queue
		send_word(FUNC_TICK, 8'hFF);
		send_word(FUNC_REQUEST, 8'h00);
		send_word(FUNC_TICK, 8'h00);
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_word(FUNC_REQUEST, (i % 4 == 0) ? 8'hFF : (i % 4 == 1) ? 8'h00 :
				(i % 4 == 2) ? 8'hAA : 8'h55);
		send_word(FUNC_TICK, 8'h00);
		drain();

		for (int p = 0; p < 6; p++) begin
			if (p == 4)
				set_config(SLOT_W'($urandom_range(4095, 1)), SLOT_W'($urandom_range(200)));
			else
				set_config(phase_frame[p[2:0]], phase_req[p[2:0]]);
			while (n_sent < 21 + (p + 1) * 65) begin
				r = $urandom_range(99);
				if (r < 10)
					n_req = 0;
				else if (r < 70)
					n_req = $urandom_range(6, 1);
				else if (r < 90)
					n_req = $urandom_range(15, 7);
				else
					n_req = $urandom_range(QUEUE_DEPTH + 3, QUEUE_DEPTH);
				send_frame(n_req);
			end
			drain();
		end

		$display("sent %0d words: %0d requests (%0d dropped on a full queue), %0d ticks",
			n_sent, n_requests, n_dropped, n_ticks);
		$display("checked %0d grant words over 7 slot settings, %0d mismatches", n_grants, errors);
		if (errors == 0 && pending == 0)
			$display("** tdma_slot_allocator: PASSED **");
		else
			$display("** tdma_slot_allocator: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
